// ===== rtl/gase_pkg.sv =====
// Shared types and constants of the grid A* search engine.
// Holds command codes, register indexes, controller states, datapath ops and the
// command/status structs that join controller and datapath. No dependencies.
package gase_pkg;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 6;
  localparam int COLOUR_W    = 2;
  localparam int COST_OUT_W  = 12;
  localparam int COUNT_OUT_W = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int EXT_W       = 9;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int WALL_LEFT  = 0;
  localparam int WALL_RIGHT = 1;
  localparam int WALL_UPPER = 2;
  localparam int WALL_LOWER = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_code_t;

  typedef enum logic [COLOUR_W-1:0] {
    COL_UNREACHED = 2'd0,
    COL_OPEN      = 2'd1,
    COL_CLOSED    = 2'd2
  } colour_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_GOAL_X      = 3'd4,
    CFG_GOAL_Y      = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UPPER = 2'd2,
    DIR_LOWER = 2'd3
  } dir_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_QREAD,
    ST_QRES,
    ST_SEED,
    ST_POP0,
    ST_POP1,
    ST_POP2,
    ST_POP3,
    ST_SD0,
    ST_SD1,
    ST_SD2,
    ST_SD3,
    ST_SD_SWB,
    ST_NB0,
    ST_NB1,
    ST_SU0,
    ST_SU1,
    ST_SU_SWA,
    ST_SU_SWB,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_LOAD,
    OP_QREAD,
    OP_QRES,
    OP_SEED,
    OP_POP0,
    OP_POP1,
    OP_POP2,
    OP_POP3,
    OP_SD_READL,
    OP_SD_LEFT,
    OP_SD_RIGHT,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_NB_READ,
    OP_NB_NEXT,
    OP_RELAX,
    OP_SU_READ,
    OP_SU_LATCH,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t in_cmd;
    logic      in_valid;
    logic      cnt_zero;
    logic      clr_last;
    logic      clr_walls;
    logic      l_ok;
    logic      r_ok;
    logic      s_eq_h;
    logic      h_zero;
    logic      su_stop;
    logic      nb_en;
    logic      nb_skip;
    logic      dir_last;
    logic      out_free;
  } dp_status_t;

endpackage

// ===== rtl/gase_in_if.sv =====
// Input channel of the grid A* search engine: valid/ready and one command item.
// Depends on gase_pkg for field widths.
interface gase_in_if;
  logic                        valid;
  logic                        ready;
  logic [gase_pkg::CMD_W-1:0]   command;
  logic [gase_pkg::COORD_W-1:0] cell_x;
  logic [gase_pkg::COORD_W-1:0] cell_y;
  logic                        wall_left;
  logic                        wall_right;
  logic                        wall_upper;
  logic                        wall_lower;

  modport source (output valid, command, cell_x, cell_y, wall_left, wall_right,
                  wall_upper, wall_lower, input ready);
  modport sink (input valid, command, cell_x, cell_y, wall_left, wall_right,
                wall_upper, wall_lower, output ready);
endinterface

// ===== rtl/gase_out_if.sv =====
// Result channel of the grid A* search engine: valid/ready and one result item.
// Depends on gase_pkg for field widths.
interface gase_out_if;
  logic                             valid;
  logic                             ready;
  logic [gase_pkg::COLOUR_W-1:0]    cell_colour;
  logic                             expanded_valid;
  logic [gase_pkg::COORD_W-1:0]     expanded_x;
  logic [gase_pkg::COORD_W-1:0]     expanded_y;
  logic [gase_pkg::COST_OUT_W-1:0]  expanded_cost;
  logic [gase_pkg::COUNT_OUT_W-1:0] open_count;
  logic                             search_empty;

  modport source (output valid, cell_colour, expanded_valid, expanded_x, expanded_y,
                  expanded_cost, open_count, search_empty, input ready);
  modport sink (input valid, cell_colour, expanded_valid, expanded_x, expanded_y,
                expanded_cost, open_count, search_empty, output ready);
endinterface

// ===== rtl/gase_ctrl.sv =====
// Controller of the grid A* search engine: sequences clear, load, query, pop,
// sift and relax steps. Depends on gase_pkg; drives gase_datapath by dp_cmd_t.
module gase_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gase_pkg::dp_status_t status,
  output gase_pkg::dp_cmd_t    cmd
);

  gase_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gase_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gase_pkg::ST_CLEAR: begin
        if (status.clr_last) begin
          state_nxt = status.clr_walls ? gase_pkg::ST_IDLE : gase_pkg::ST_SEED;
        end
      end
      gase_pkg::ST_IDLE: begin
        if (status.in_valid) begin
          case (status.in_cmd)
            gase_pkg::CMD_LOAD:  state_nxt = gase_pkg::ST_LOAD;
            gase_pkg::CMD_START: state_nxt = gase_pkg::ST_CLEAR;
            gase_pkg::CMD_STEP:  state_nxt = gase_pkg::ST_POP0;
            gase_pkg::CMD_QUERY: state_nxt = gase_pkg::ST_QREAD;
            default:             state_nxt = gase_pkg::ST_IDLE;
          endcase
        end
      end
      gase_pkg::ST_LOAD:  state_nxt = gase_pkg::ST_DONE;
      gase_pkg::ST_QREAD: state_nxt = gase_pkg::ST_QRES;
      gase_pkg::ST_QRES:  state_nxt = gase_pkg::ST_DONE;
      gase_pkg::ST_SEED:  state_nxt = gase_pkg::ST_DONE;
      gase_pkg::ST_POP0: begin
        state_nxt = status.cnt_zero ? gase_pkg::ST_DONE : gase_pkg::ST_POP1;
      end
      gase_pkg::ST_POP1: state_nxt = gase_pkg::ST_POP2;
      gase_pkg::ST_POP2: state_nxt = gase_pkg::ST_POP3;
      gase_pkg::ST_POP3: state_nxt = gase_pkg::ST_SD0;
      gase_pkg::ST_SD0: begin
        state_nxt = status.l_ok ? gase_pkg::ST_SD1 : gase_pkg::ST_NB0;
      end
      gase_pkg::ST_SD1: begin
        state_nxt = status.r_ok ? gase_pkg::ST_SD2 : gase_pkg::ST_SD3;
      end
      gase_pkg::ST_SD2: state_nxt = gase_pkg::ST_SD3;
      gase_pkg::ST_SD3: begin
        state_nxt = status.s_eq_h ? gase_pkg::ST_NB0 : gase_pkg::ST_SD_SWB;
      end
      gase_pkg::ST_SD_SWB: state_nxt = gase_pkg::ST_SD0;
      gase_pkg::ST_NB0: begin
        if (status.nb_en) begin
          state_nxt = gase_pkg::ST_NB1;
        end else begin
          state_nxt = status.dir_last ? gase_pkg::ST_DONE : gase_pkg::ST_NB0;
        end
      end
      gase_pkg::ST_NB1: begin
        if (status.nb_skip) begin
          state_nxt = status.dir_last ? gase_pkg::ST_DONE : gase_pkg::ST_NB0;
        end else begin
          state_nxt = gase_pkg::ST_SU0;
        end
      end
      gase_pkg::ST_SU0: begin
        if (status.h_zero) begin
          state_nxt = status.dir_last ? gase_pkg::ST_DONE : gase_pkg::ST_NB0;
        end else begin
          state_nxt = gase_pkg::ST_SU1;
        end
      end
      gase_pkg::ST_SU1: begin
        if (status.su_stop) begin
          state_nxt = status.dir_last ? gase_pkg::ST_DONE : gase_pkg::ST_NB0;
        end else begin
          state_nxt = gase_pkg::ST_SU_SWA;
        end
      end
      gase_pkg::ST_SU_SWA: state_nxt = gase_pkg::ST_SU_SWB;
      gase_pkg::ST_SU_SWB: state_nxt = gase_pkg::ST_SU0;
      gase_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_nxt = gase_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gase_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = gase_pkg::OP_NONE;
    cmd.in_ready = 1'b0;
    case (state_r)
      gase_pkg::ST_CLEAR: cmd.op = gase_pkg::OP_CLEAR;
      gase_pkg::ST_IDLE: begin
        cmd.op       = gase_pkg::OP_CAPTURE;
        cmd.in_ready = 1'b1;
      end
      gase_pkg::ST_LOAD:  cmd.op = gase_pkg::OP_LOAD;
      gase_pkg::ST_QREAD: cmd.op = gase_pkg::OP_QREAD;
      gase_pkg::ST_QRES:  cmd.op = gase_pkg::OP_QRES;
      gase_pkg::ST_SEED:  cmd.op = gase_pkg::OP_SEED;
      gase_pkg::ST_POP0: begin
        cmd.op = status.cnt_zero ? gase_pkg::OP_NONE : gase_pkg::OP_POP0;
      end
      gase_pkg::ST_POP1: cmd.op = gase_pkg::OP_POP1;
      gase_pkg::ST_POP2: cmd.op = gase_pkg::OP_POP2;
      gase_pkg::ST_POP3: cmd.op = gase_pkg::OP_POP3;
      gase_pkg::ST_SD0: begin
        cmd.op = status.l_ok ? gase_pkg::OP_SD_READL : gase_pkg::OP_NONE;
      end
      gase_pkg::ST_SD1: cmd.op = gase_pkg::OP_SD_LEFT;
      gase_pkg::ST_SD2: cmd.op = gase_pkg::OP_SD_RIGHT;
      gase_pkg::ST_SD3: begin
        cmd.op = status.s_eq_h ? gase_pkg::OP_NONE : gase_pkg::OP_SWAP_A;
      end
      gase_pkg::ST_SD_SWB: cmd.op = gase_pkg::OP_SWAP_B;
      gase_pkg::ST_NB0: begin
        cmd.op = status.nb_en ? gase_pkg::OP_NB_READ : gase_pkg::OP_NB_NEXT;
      end
      gase_pkg::ST_NB1: begin
        cmd.op = status.nb_skip ? gase_pkg::OP_NB_NEXT : gase_pkg::OP_RELAX;
      end
      gase_pkg::ST_SU0: begin
        cmd.op = status.h_zero ? gase_pkg::OP_NB_NEXT : gase_pkg::OP_SU_READ;
      end
      gase_pkg::ST_SU1: begin
        cmd.op = status.su_stop ? gase_pkg::OP_NB_NEXT : gase_pkg::OP_SU_LATCH;
      end
      gase_pkg::ST_SU_SWA: cmd.op = gase_pkg::OP_SWAP_A;
      gase_pkg::ST_SU_SWB: cmd.op = gase_pkg::OP_SWAP_B;
      gase_pkg::ST_DONE: begin
        cmd.op = status.out_free ? gase_pkg::OP_FINISH : gase_pkg::OP_NONE;
      end
      default: cmd.op = gase_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== rtl/gase_datapath.sv =====
// Datapath of the grid A* search engine: config registers, wall, node and heap
// memories, heap working registers and the output register. Depends on gase_pkg
// and the gase_in_if / gase_out_if interfaces; driven by gase_ctrl.
module gase_datapath #(
  parameter int MAX_COLUMNS = gase_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gase_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  gase_in_if.sink                            in_ch,
  gase_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [gase_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gase_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  gase_pkg::dp_cmd_t                  cmd,
  output gase_pkg::dp_status_t               status
);

  localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int XW     = $clog2(MAX_COLUMNS);
  localparam int YW     = $clog2(MAX_ROWS);
  localparam int AW     = $clog2(NCELLS);
  localparam int HIW    = AW;
  localparam int LW     = HIW + 2;
  localparam int CNTW   = $clog2(NCELLS + 1);
  localparam int CSTW   = AW + 1;
  localparam int WW     = CSTW + 10;
  localparam int EW     = gase_pkg::EXT_W;
  localparam int CW     = gase_pkg::COORD_W;

  typedef struct packed {
    logic [CSTW-1:0] cost;
    logic [YW-1:0]   y;
    logic [XW-1:0]   x;
  } entry_t;

  typedef struct packed {
    logic            reached;
    logic            in_heap;
    logic [CSTW-1:0] cost;
    logic [HIW-1:0]  pos;
  } node_t;

  function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y,
                                                input logic [XW-1:0] x);
    cell_addr = AW'(int'(y) * MAX_COLUMNS + int'(x));
  endfunction

  function automatic logic [WW-1:0] weight(input entry_t e, input logic [CW-1:0] gx,
                                           input logic [CW-1:0] gy);
    logic [EW-1:0] ex, ey, g1, g2, dx, dy;
    ex = EW'(e.x);
    ey = EW'(e.y);
    g1 = EW'(gx);
    g2 = EW'(gy);
    dx = (ex >= g1) ? ex - g1 : g1 - ex;
    dy = (ey >= g2) ? ey - g2 : g2 - ey;
    weight = WW'(e.cost) + WW'(dx) + WW'(dy);
  endfunction

  logic [3:0] wall_mem [NCELLS];
  node_t      node_mem [NCELLS];
  entry_t     heap_mem [NCELLS];

  logic [gase_pkg::CFG_DATA_W-1:0] gw_r, gh_r;
  logic [CW-1:0]                   sx_r, sy_r, gx_r, gy_r;

  logic [CW-1:0]         cx_r, cy_r;
  logic [3:0]            wl_r;
  logic [CNTW-1:0]       count_r;
  entry_t                rt_r, cur_r, sel_r;
  logic [3:0]            rw_r;
  logic [HIW-1:0]        h_r, s_r;
  gase_pkg::dir_t        dir_r;
  logic [AW-1:0]         clr_r;
  logic                  clr_walls_r;
  logic [gase_pkg::COLOUR_W-1:0]   colour_r;
  logic                            xv_r;
  logic [CW-1:0]                   ex_r, ey_r;
  logic [gase_pkg::COST_OUT_W-1:0] ecost_r;
  logic                            out_valid_r;

  logic [3:0] wall_q;
  node_t      node_q;
  entry_t     heap_q;

  logic [EW-1:0]   weff, heff, sx9, sy9;
  logic            in_range, clr_last;
  logic [AW-1:0]   q_addr, n_addr;
  logic [XW-1:0]   nx;
  logic [YW-1:0]   ny;
  logic            nb_en;
  logic [CSTW-1:0] nc;
  logic [LW-1:0]   l_idx, r_idx;
  logic [HIW-1:0]  p_idx, push_pos;
  logic [WW-1:0]   w_q, w_cur, w_sel;
  entry_t          seed_e;
  logic            accept;

  logic            wall_we, wall_re;
  logic [AW-1:0]   wall_waddr, wall_raddr;
  logic [3:0]      wall_wdata;
  logic            node_we, node_re;
  logic [AW-1:0]   node_waddr, node_raddr;
  node_t           node_wdata;
  logic            heap_we, heap_re;
  logic [HIW-1:0]  heap_waddr, heap_raddr;
  entry_t          heap_wdata;

  always_comb begin
    if (gw_r == '0) begin
      weff = EW'(1);
    end else if (EW'(gw_r) > EW'(MAX_COLUMNS)) begin
      weff = EW'(MAX_COLUMNS);
    end else begin
      weff = EW'(gw_r);
    end
    if (gh_r == '0) begin
      heff = EW'(1);
    end else if (EW'(gh_r) > EW'(MAX_ROWS)) begin
      heff = EW'(MAX_ROWS);
    end else begin
      heff = EW'(gh_r);
    end
    sx9 = (EW'(sx_r) >= weff) ? weff - EW'(1) : EW'(sx_r);
    sy9 = (EW'(sy_r) >= heff) ? heff - EW'(1) : EW'(sy_r);
  end

  assign seed_e   = '{cost: '0, y: YW'(sy9), x: XW'(sx9)};
  assign in_range = (EW'(cx_r) < EW'(MAX_COLUMNS)) && (EW'(cy_r) < EW'(MAX_ROWS));
  assign q_addr   = cell_addr(YW'(cy_r), XW'(cx_r));
  assign clr_last = (clr_r == AW'(NCELLS - 1));
  assign nc       = rt_r.cost + CSTW'(1);
  assign l_idx    = LW'({h_r, 1'b1});
  assign r_idx    = l_idx + LW'(1);
  assign p_idx    = HIW'((h_r - HIW'(1)) >> 1);
  assign push_pos = HIW'(count_r);
  assign w_q      = weight(heap_q, gx_r, gy_r);
  assign w_cur    = weight(cur_r, gx_r, gy_r);
  assign w_sel    = weight(sel_r, gx_r, gy_r);
  assign accept   = in_ch.valid && cmd.in_ready;

  always_comb begin
    nx    = rt_r.x;
    ny    = rt_r.y;
    nb_en = 1'b0;
    case (dir_r)
      gase_pkg::DIR_LEFT: begin
        nx    = rt_r.x - XW'(1);
        nb_en = !rw_r[gase_pkg::WALL_LEFT] && (rt_r.x != '0);
      end
      gase_pkg::DIR_RIGHT: begin
        nx    = rt_r.x + XW'(1);
        nb_en = !rw_r[gase_pkg::WALL_RIGHT] && (EW'(rt_r.x) + EW'(1) < weff);
      end
      gase_pkg::DIR_UPPER: begin
        ny    = rt_r.y - YW'(1);
        nb_en = !rw_r[gase_pkg::WALL_UPPER] && (rt_r.y != '0);
      end
      gase_pkg::DIR_LOWER: begin
        ny    = rt_r.y + YW'(1);
        nb_en = !rw_r[gase_pkg::WALL_LOWER] && (EW'(rt_r.y) + EW'(1) < heff);
      end
      default: nb_en = 1'b0;
    endcase
  end

  assign n_addr = cell_addr(ny, nx);

  always_comb begin
    wall_we    = 1'b0;
    wall_waddr = clr_r;
    wall_wdata = 4'hF;
    wall_re    = 1'b0;
    wall_raddr = cell_addr(heap_q.y, heap_q.x);
    node_we    = 1'b0;
    node_waddr = clr_r;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = q_addr;
    heap_we    = 1'b0;
    heap_waddr = '0;
    heap_wdata = seed_e;
    heap_re    = 1'b0;
    heap_raddr = '0;
    case (cmd.op)
      gase_pkg::OP_CLEAR: begin
        node_we = 1'b1;
        wall_we = clr_walls_r;
      end
      gase_pkg::OP_LOAD: begin
        wall_we    = in_range;
        wall_waddr = q_addr;
        wall_wdata = wl_r;
      end
      gase_pkg::OP_QREAD: node_re = in_range;
      gase_pkg::OP_SEED: begin
        heap_we    = 1'b1;
        node_we    = 1'b1;
        node_waddr = cell_addr(seed_e.y, seed_e.x);
        node_wdata = '{reached: 1'b1, in_heap: 1'b1, cost: '0, pos: '0};
      end
      gase_pkg::OP_POP0: heap_re = 1'b1;
      gase_pkg::OP_POP1: begin
        heap_re    = 1'b1;
        heap_raddr = HIW'(count_r - CNTW'(1));
        wall_re    = 1'b1;
      end
      gase_pkg::OP_POP2: begin
        heap_we    = 1'b1;
        heap_wdata = heap_q;
        node_we    = 1'b1;
        node_waddr = cell_addr(heap_q.y, heap_q.x);
        node_wdata = '{reached: 1'b1, in_heap: 1'b1, cost: heap_q.cost, pos: '0};
      end
      gase_pkg::OP_POP3: begin
        node_we    = 1'b1;
        node_waddr = cell_addr(rt_r.y, rt_r.x);
        node_wdata = '{reached: 1'b1, in_heap: 1'b0, cost: rt_r.cost, pos: '0};
      end
      gase_pkg::OP_SD_READL: begin
        heap_re    = 1'b1;
        heap_raddr = HIW'(l_idx);
      end
      gase_pkg::OP_SD_LEFT: begin
        heap_re    = (r_idx < LW'(count_r));
        heap_raddr = HIW'(r_idx);
      end
      gase_pkg::OP_SWAP_A: begin
        heap_we    = 1'b1;
        heap_waddr = h_r;
        heap_wdata = sel_r;
        node_we    = 1'b1;
        node_waddr = cell_addr(sel_r.y, sel_r.x);
        node_wdata = '{reached: 1'b1, in_heap: 1'b1, cost: sel_r.cost, pos: h_r};
      end
      gase_pkg::OP_SWAP_B: begin
        heap_we    = 1'b1;
        heap_waddr = s_r;
        heap_wdata = cur_r;
        node_we    = 1'b1;
        node_waddr = cell_addr(cur_r.y, cur_r.x);
        node_wdata = '{reached: 1'b1, in_heap: 1'b1, cost: cur_r.cost, pos: s_r};
      end
      gase_pkg::OP_NB_READ: begin
        node_re    = 1'b1;
        node_raddr = n_addr;
      end
      gase_pkg::OP_RELAX: begin
        heap_we    = 1'b1;
        heap_waddr = node_q.in_heap ? node_q.pos : push_pos;
        heap_wdata = '{cost: nc, y: ny, x: nx};
        node_we    = 1'b1;
        node_waddr = n_addr;
        node_wdata = '{reached: 1'b1, in_heap: 1'b1, cost: nc,
                       pos: (node_q.in_heap ? node_q.pos : push_pos)};
      end
      gase_pkg::OP_SU_READ: begin
        heap_re    = 1'b1;
        heap_raddr = p_idx;
      end
      default: heap_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    if (wall_re) begin
      wall_q <= wall_mem[wall_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_q <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    if (heap_re) begin
      heap_q <= heap_mem[heap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= gase_pkg::CFG_DATA_W'(64);
      gh_r <= gase_pkg::CFG_DATA_W'(64);
      sx_r <= '0;
      sy_r <= '0;
      gx_r <= CW'(63);
      gy_r <= CW'(63);
    end else if (cfg_we) begin
      case (gase_pkg::cfg_reg_t'(cfg_index))
        gase_pkg::CFG_GRID_WIDTH:  gw_r <= cfg_wdata;
        gase_pkg::CFG_GRID_HEIGHT: gh_r <= cfg_wdata;
        gase_pkg::CFG_START_X:     sx_r <= CW'(cfg_wdata);
        gase_pkg::CFG_START_Y:     sy_r <= CW'(cfg_wdata);
        gase_pkg::CFG_GOAL_X:      gx_r <= CW'(cfg_wdata);
        gase_pkg::CFG_GOAL_Y:      gy_r <= CW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_r       <= '0;
      clr_walls_r <= 1'b1;
      out_valid_r <= 1'b0;
      dir_r       <= gase_pkg::DIR_LEFT;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        gase_pkg::OP_CAPTURE: begin
          if (accept) begin
            cx_r     <= in_ch.cell_x;
            cy_r     <= in_ch.cell_y;
            wl_r     <= {in_ch.wall_lower, in_ch.wall_upper, in_ch.wall_right,
                         in_ch.wall_left};
            colour_r <= gase_pkg::COL_UNREACHED;
            xv_r     <= 1'b0;
            ex_r     <= '0;
            ey_r     <= '0;
            ecost_r  <= '0;
          end
        end
        gase_pkg::OP_CLEAR: begin
          if (clr_last) begin
            clr_r       <= '0;
            clr_walls_r <= 1'b0;
          end else begin
            clr_r <= clr_r + AW'(1);
          end
        end
        gase_pkg::OP_QRES: begin
          if (in_range && node_q.in_heap) begin
            colour_r <= gase_pkg::COL_OPEN;
          end else if (in_range && node_q.reached) begin
            colour_r <= gase_pkg::COL_CLOSED;
          end
        end
        gase_pkg::OP_SEED: count_r <= CNTW'(1);
        gase_pkg::OP_POP0: dir_r <= gase_pkg::DIR_LEFT;
        gase_pkg::OP_POP1: begin
          rt_r    <= heap_q;
          count_r <= count_r - CNTW'(1);
          xv_r    <= 1'b1;
          ex_r    <= CW'(heap_q.x);
          ey_r    <= CW'(heap_q.y);
          ecost_r <= gase_pkg::COST_OUT_W'(heap_q.cost);
        end
        gase_pkg::OP_POP2: begin
          cur_r <= heap_q;
          rw_r  <= wall_q;
          h_r   <= '0;
        end
        gase_pkg::OP_SD_LEFT: begin
          if (w_q <= w_cur) begin
            sel_r <= heap_q;
            s_r   <= HIW'(l_idx);
          end else begin
            sel_r <= cur_r;
            s_r   <= h_r;
          end
        end
        gase_pkg::OP_SD_RIGHT: begin
          if (w_q <= w_sel) begin
            sel_r <= heap_q;
            s_r   <= HIW'(r_idx);
          end
        end
        gase_pkg::OP_SWAP_B: h_r <= s_r;
        gase_pkg::OP_NB_NEXT: dir_r <= gase_pkg::dir_t'(2'(dir_r) + 2'd1);
        gase_pkg::OP_RELAX: begin
          cur_r <= '{cost: nc, y: ny, x: nx};
          if (node_q.in_heap) begin
            h_r <= node_q.pos;
          end else begin
            h_r     <= push_pos;
            count_r <= count_r + CNTW'(1);
          end
        end
        gase_pkg::OP_SU_READ:  s_r <= p_idx;
        gase_pkg::OP_SU_LATCH: sel_r <= heap_q;
        gase_pkg::OP_FINISH: begin
          out_valid_r           <= 1'b1;
          out_ch.cell_colour    <= colour_r;
          out_ch.expanded_valid <= xv_r;
          out_ch.expanded_x     <= ex_r;
          out_ch.expanded_y     <= ey_r;
          out_ch.expanded_cost  <= ecost_r;
          out_ch.open_count     <= gase_pkg::COUNT_OUT_W'(count_r);
          out_ch.search_empty   <= (count_r == '0);
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = cmd.in_ready;
  assign out_ch.valid = out_valid_r;

  always_comb begin
    status.in_cmd    = gase_pkg::cmd_code_t'(in_ch.command);
    status.in_valid  = in_ch.valid;
    status.cnt_zero  = (count_r == '0);
    status.clr_last  = clr_last;
    status.clr_walls = clr_walls_r;
    status.l_ok      = (l_idx < LW'(count_r));
    status.r_ok      = (r_idx < LW'(count_r));
    status.s_eq_h    = (s_r == h_r);
    status.h_zero    = (h_r == '0);
    status.su_stop   = (w_cur > w_q);
    status.nb_en     = nb_en;
    status.nb_skip   = node_q.reached && (!node_q.in_heap || (nc >= node_q.cost));
    status.dir_last  = (dir_r == gase_pkg::DIR_LOWER);
    status.out_free  = !out_valid_r || out_ch.ready;
  end

endmodule

// ===== rtl/grid_astar_search_engine.sv =====
// Grid A* search engine: one command item in, one result item out, one at a time.
// Load writes one cell's walls, query reads one cell's node entry, start runs a
// node clearing sweep and seeds the heap. Step pops the heap top and sifts the
// heap down, then relaxes each reachable neighbour and sifts it up.
// After rst_n (synchronous, active low) a sweep over all MAX_COLUMNS*MAX_ROWS cells
// sets all walls closed and all cells unreached; no item is taken until it ends.
module grid_astar_search_engine #(
  parameter int MAX_COLUMNS = gase_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gase_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gase_in_if.sink                         in_ch,
  gase_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [gase_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gase_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gase_pkg::dp_cmd_t    cmd;
  gase_pkg::dp_status_t status;

  gase_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  gase_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/gase_checker.sv =====
// Port-level checks of the grid A* search engine result channel, bound to the
// top level. Depends on gase_pkg for field widths.
module gase_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [gase_pkg::COLOUR_W-1:0]    cell_colour,
  input logic                             expanded_valid,
  input logic [gase_pkg::COORD_W-1:0]     expanded_x,
  input logic [gase_pkg::COORD_W-1:0]     expanded_y,
  input logic [gase_pkg::COST_OUT_W-1:0]  expanded_cost,
  input logic [gase_pkg::COUNT_OUT_W-1:0] open_count,
  input logic                             search_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (search_empty == (open_count == '0)))
    else $error("empty flag disagrees with open count");

  a_no_expand_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !expanded_valid |->
      (expanded_x == '0) && (expanded_y == '0) && (expanded_cost == '0))
    else $error("expanded fields set without an expanded cell");

  a_colour_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cell_colour != '0) |->
      !expanded_valid && (cell_colour != 2'd3))
    else $error("colour reported outside a query");

endmodule

bind grid_astar_search_engine gase_checker u_gase_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cell_colour    (out_ch.cell_colour),
  .expanded_valid (out_ch.expanded_valid),
  .expanded_x     (out_ch.expanded_x),
  .expanded_y     (out_ch.expanded_y),
  .expanded_cost  (out_ch.expanded_cost),
  .open_count     (out_ch.open_count),
  .search_empty   (out_ch.search_empty)
);

// ===== verif/gase_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side channel instances are the RTL interfaces gase_in_if and gase_out_if.
// This file only holds a small package of testbench types; depends on gase_pkg.
package gase_tb_pkg;
  import gase_pkg::*;

  typedef struct packed {
    cmd_code_t         command;
    logic [5:0]        cell_x;
    logic [5:0]        cell_y;
    logic [3:0]        walls;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]        cell_colour;
    logic              expanded_valid;
    logic [5:0]        expanded_x;
    logic [5:0]        expanded_y;
    logic [11:0]       expanded_cost;
    logic [12:0]       open_count;
    logic              search_empty;
  } result_item_t;
endpackage

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of grid_astar_search_engine: directed table, then random
// mazes searched step by step, checked against an A* predictor. Needs gase_pkg and
// the channel interfaces.
module testbench;
  import gase_pkg::*;
  import gase_tb_pkg::*;

  localparam int NC = 64 * 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gase_in_if in_ch ();
  gase_out_if out_ch ();

  grid_astar_search_engine i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  int unsigned gw, gh, sxr, syr, gxr, gyr;
  logic [3:0]  walls_m [NC];
  int unsigned cost_m [NC];
  bit          reached_m [NC];
  int unsigned hpos_m [NC];
  bit          inheap_m [NC];
  int unsigned heap_m [NC];
  int unsigned hcnt;

  result_item_t pending_results[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_steps_valid = 0;
  longint cycles = 0;
  bit long_hold = 0;
  bit stim_done = 0;

  function automatic int unsigned adiff(int unsigned a, int unsigned b);
    return a < b ? b - a : a - b;
  endfunction

  function automatic int unsigned ew();
    return gw == 0 ? 1 : (gw > 64 ? 64 : gw);
  endfunction

  function automatic int unsigned eh();
    return gh == 0 ? 1 : (gh > 64 ? 64 : gh);
  endfunction

  function automatic int unsigned fscore(int unsigned h);
    int unsigned c;
    c = heap_m[h];
    return cost_m[c] + adiff(c % 64, gxr) + adiff(c / 64, gyr);
  endfunction

  function automatic void hswap(int unsigned a, int unsigned b);
    int unsigned ca, cb;
    ca = heap_m[a];
    cb = heap_m[b];
    heap_m[a] = cb;
    heap_m[b] = ca;
    hpos_m[cb] = a;
    hpos_m[ca] = b;
  endfunction

  function automatic void sift_up(int unsigned h);
    int unsigned p;
    while (h > 0) begin
      p = (h - 1) / 2;
      if (fscore(h) > fscore(p)) break;
      hswap(h, p);
      h = p;
    end
  endfunction

  function automatic void sift_down(int unsigned h);
    int unsigned l, r, s;
    forever begin
      l = 2 * h + 1;
      r = 2 * h + 2;
      s = h;
      if (l < hcnt && fscore(l) <= fscore(s)) s = l;
      if (r < hcnt && fscore(r) <= fscore(s)) s = r;
      if (s == h) return;
      hswap(h, s);
      h = s;
    end
  endfunction

  function automatic void relax(int unsigned c, int unsigned nc);
    if (reached_m[c] && !inheap_m[c]) return;
    if (reached_m[c] && nc >= cost_m[c]) return;
    cost_m[c] = nc;
    reached_m[c] = 1;
    if (!inheap_m[c]) begin
      heap_m[hcnt] = c;
      hpos_m[c] = hcnt;
      inheap_m[c] = 1;
      hcnt++;
    end
    sift_up(hpos_m[c]);
  endfunction

  function automatic void predictor_reset();
    gw = 64; gh = 64; sxr = 0; syr = 0; gxr = 63; gyr = 63;
    for (int i = 0; i < NC; i++) begin
      walls_m[i] = 4'hF; cost_m[i] = 0; reached_m[i] = 0;
      hpos_m[i] = 0; inheap_m[i] = 0; heap_m[i] = 0;
    end
    hcnt = 0;
  endfunction

  function automatic result_item_t predict_search(cmd_item_t it);
    result_item_t r;
    int unsigned w, hg, c, x, y, nc, sx, sy;
    logic [3:0] wb;
    r = '0;
    w = ew();
    hg = eh();
    case (it.command)
      CMD_LOAD: walls_m[it.cell_y * 64 + it.cell_x] = it.walls;
      CMD_START: begin
        sx = sxr >= w ? w - 1 : sxr;
        sy = syr >= hg ? hg - 1 : syr;
        c = sy * 64 + sx;
        for (int i = 0; i < NC; i++) begin
          reached_m[i] = 0; inheap_m[i] = 0; cost_m[i] = 0; hpos_m[i] = 0;
        end
        heap_m[0] = c; hcnt = 1; reached_m[c] = 1; inheap_m[c] = 1;
      end
      CMD_STEP: begin
        if (hcnt > 0) begin
          c = heap_m[0];
          x = c % 64;
          y = c / 64;
          wb = walls_m[c];
          hcnt--;
          heap_m[0] = heap_m[hcnt];
          hpos_m[heap_m[0]] = 0;
          inheap_m[c] = 0;
          sift_down(0);
          r.expanded_valid = 1;
          r.expanded_x = x;
          r.expanded_y = y;
          r.expanded_cost = cost_m[c][11:0];
          nc = cost_m[c] + 1;
          if (!wb[WALL_LEFT] && x > 0) relax(c - 1, nc);
          if (!wb[WALL_RIGHT] && x + 1 < w) relax(c + 1, nc);
          if (!wb[WALL_UPPER] && y > 0) relax(c - 64, nc);
          if (!wb[WALL_LOWER] && y + 1 < hg) relax(c + 64, nc);
        end
      end
      default: begin
        c = it.cell_y * 64 + it.cell_x;
        if (inheap_m[c]) r.cell_colour = COL_OPEN;
        else if (reached_m[c]) r.cell_colour = COL_CLOSED;
      end
    endcase
    r.open_count = hcnt[12:0];
    r.search_empty = (hcnt == 0);
    return r;
  endfunction

  function automatic cmd_item_t mk(cmd_code_t cmd, int x, int y, int wl);
    cmd_item_t it;
    it.command = cmd;
    it.cell_x = x;
    it.cell_y = y;
    it.walls = wl;
    return it;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    {in_ch.wall_left, in_ch.wall_right, in_ch.wall_upper, in_ch.wall_lower} = '0;
    out_ch.ready = 1'b0;
  end

  // send one item; expected result computed at acceptance
  task automatic send_cmd(cmd_item_t it, bit has_exp, result_item_t exp_r);
    result_item_t p;
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.cell_x <= it.cell_x;
    in_ch.cell_y <= it.cell_y;
    {in_ch.wall_lower, in_ch.wall_upper, in_ch.wall_right, in_ch.wall_left} <= it.walls;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_search(it);
    if (has_exp && p != exp_r) begin
      $display("%0t table mismatch expected %h actual %h", $time, exp_r, p);
      errors++;
    end
    pending_results.push_back(p);
    n_items++;
  endtask

  task automatic gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GRID_WIDTH:  gw = v & 7'h7F;
      CFG_GRID_HEIGHT: gh = v & 7'h7F;
      CFG_START_X:     sxr = v & 6'h3F;
      CFG_START_Y:     syr = v & 6'h3F;
      CFG_GOAL_X:      gxr = v & 6'h3F;
      default:         gyr = v & 6'h3F;
    endcase
  endtask

  always @(posedge clk) begin
    result_item_t got, want;
    cycles++;
    if (cycles > 3000000) begin
      $display("testbench: FAIL");
      $finish;
    end
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.cell_colour, out_ch.expanded_valid, out_ch.expanded_x,
             out_ch.expanded_y, out_ch.expanded_cost, out_ch.open_count,
             out_ch.search_empty};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (got.expanded_valid) n_steps_valid++;
        if (got != want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int k;
    k = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      k++;
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
        out_ch.ready <= 1'b1;
      end else if (k % 200 < 60) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic random_maze(int unsigned w, int unsigned hg, int steps);
    for (int i = 0; i < 12; i++) begin
      send_cmd(mk(CMD_LOAD, $urandom_range(0, w - 1), $urandom_range(0, hg - 1),
                  $urandom_range(0, 15)), 0, '0);
      gap();
    end
    send_cmd(mk(CMD_START, 0, 0, 0), 0, '0);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_cmd(mk(CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 15)), 0, '0);
      else if ($urandom_range(0, 19) == 0)
        send_cmd(mk(cmd_code_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 15)), 0, '0);
      else
        send_cmd(mk(CMD_STEP, $urandom, $urandom, $urandom), 0, '0);
      gap();
    end
  endtask

  initial begin
    cmd_item_t     tbl_item [$];
    bit            tbl_has [$];
    result_item_t  tbl_exp [$];
    result_item_t  e_empty, e_one;
    int unsigned   w, hg;
    predictor_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    e_empty = '0; e_empty.search_empty = 1;
    e_one = '0; e_one.open_count = 1;
    // directed table
    tbl_item = '{mk(CMD_STEP, 0, 0, 0), mk(CMD_QUERY, 63, 63, 0),
                 mk(CMD_START, 0, 0, 0), mk(CMD_QUERY, 0, 0, 0),
                 mk(CMD_LOAD, 0, 0, 0), mk(CMD_LOAD, 1, 0, 15), mk(CMD_LOAD, 63, 63, 0),
                 mk(CMD_LOAD, 63, 0, 5), mk(CMD_LOAD, 0, 63, 10),
                 mk(CMD_START, 0, 0, 0), mk(CMD_STEP, 0, 0, 0), mk(CMD_STEP, 0, 0, 0),
                 mk(CMD_STEP, 0, 0, 0), mk(CMD_QUERY, 0, 0, 15), mk(CMD_QUERY, 1, 0, 0),
                 mk(CMD_QUERY, 0, 1, 0), mk(CMD_STEP, 0, 0, 0)};
    tbl_has = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
    tbl_exp = '{e_empty, e_empty, e_one, '0, '0, '0, '0, '0, '0, e_one,
                '0, '0, '0, '0, '0, '0, '0};
    for (int i = 0; i < tbl_item.size(); i++) begin
      send_cmd(tbl_item[i], tbl_has[i], tbl_exp[i]);
      gap();
    end
    drain();
    // small grids, extremes of registers
    write_reg(CFG_GRID_WIDTH, 0);
    write_reg(CFG_GRID_HEIGHT, 127);
    write_reg(CFG_START_X, 63);
    write_reg(CFG_START_Y, 63);
    write_reg(CFG_GOAL_X, 0);
    write_reg(CFG_GOAL_Y, 0);
    random_maze(1, 64, 20);
    drain();
    write_reg(CFG_GRID_WIDTH, 64);
    write_reg(CFG_GRID_HEIGHT, 1);
    random_maze(64, 1, 20);
    drain();
    long_hold = 1;
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      w = $urandom_range(2, 8);
      hg = $urandom_range(2, 8);
      write_reg(CFG_GRID_WIDTH, w);
      write_reg(CFG_GRID_HEIGHT, hg);
      write_reg(CFG_START_X, $urandom_range(0, 9));
      write_reg(CFG_START_Y, $urandom_range(0, 9));
      write_reg(CFG_GOAL_X, $urandom_range(0, 63));
      write_reg(CFG_GOAL_Y, $urandom_range(0, 63));
      for (int i = 0; i < w * hg; i++)
        send_cmd(mk(CMD_LOAD, i % w, i / w, $urandom_range(0, 15) & $urandom_range(0, 15)),
                 0, '0);
      random_maze(w, hg, 30);
    end
    drain();
    stim_done = 1;
    $display("run covered %0d items and %0d results, %0d cells expanded", n_items,
             n_results, n_steps_valid);
    $display("grids from 1 column or row up to 64, saturated start and edge walls");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// ===== grid_astar_search_engine.f =====
rtl/gase_pkg.sv
rtl/gase_in_if.sv
rtl/gase_out_if.sv
rtl/gase_ctrl.sv
rtl/gase_datapath.sv
rtl/grid_astar_search_engine.sv
rtl/gase_checker.sv
verif/gase_tb_if.sv
verif/testbench.sv
